>>> rtl/scvm_pkg.sv
package scvm_pkg;

  // Result kinds as they appear on the result channel
  typedef enum logic [2:0] {
    EV_CHAR_OUT = 3'd0,
    EV_CHAR_VM  = 3'd1,
    EV_FOCUS    = 3'd2,
    EV_VERBOSE  = 3'd3,
    EV_BREAK    = 3'd4
  } event_kind_t;

  // Characters the escape decoder and the line store look for
  localparam logic [7:0] ESC_CODE   = 8'h1b;
  localparam logic [7:0] CHAR_N     = 8'h6e;
  localparam logic [7:0] CHAR_S     = 8'h73;
  localparam logic [7:0] CHAR_LF    = 8'h0a;
  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  // Field widths fixed by the item formats
  localparam int SLOT_W = 4;
  localparam int POS_W  = 5;
  localparam int MASK_W = 16;

  // Access request from the sequencer to the stores
  typedef struct packed {
    logic              len_rd;
    logic              len_we;
    logic [SLOT_W-1:0] len_slot;
    logic [POS_W-1:0]  len_wdata;
    logic              line_rd;
    logic              line_we;
    logic [SLOT_W-1:0] line_slot;
    logic [POS_W-1:0]  line_pos;
    logic [7:0]        line_wdata;
  } store_req_t;

  // Registered read data from the stores
  typedef struct packed {
    logic [POS_W-1:0] len_q;
    logic [7:0]       line_q;
  } store_rsp_t;

  // One result beat
  typedef struct packed {
    event_kind_t       kind;
    logic [7:0]        data;
    logic [SLOT_W-1:0] focus;
    logic              verbose;
    logic              last;
  } result_t;

endpackage

>>> rtl/scvm_if.sv
interface scvm_item_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [3:0] source_vm;
  logic [7:0] data_byte;

  modport source(output valid, command, source_vm, data_byte, input ready);
  modport sink(input valid, command, source_vm, data_byte, output ready);
endinterface

interface scvm_result_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_kind;
  logic [7:0] out_byte;
  logic [3:0] focus_slot;
  logic       verbose_on;
  logic       last_of_run;

  modport source(output valid, event_kind, out_byte, focus_slot, verbose_on, last_of_run,
                 input ready);
  modport sink(input valid, event_kind, out_byte, focus_slot, verbose_on, last_of_run,
               output ready);
endinterface

>>> rtl/scvm_store.sv
module scvm_store #(
  parameter int VM_SLOTS  = 16,
  parameter int LINE_SIZE = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  scvm_pkg::store_req_t   req,
  output scvm_pkg::store_rsp_t   rsp
);
  import scvm_pkg::*;

  localparam int SW    = $clog2(VM_SLOTS);
  localparam int DEPTH = VM_SLOTS * LINE_SIZE;
  localparam int AW    = $clog2(DEPTH);

  logic [POS_W-1:0] len_mem [VM_SLOTS];
  logic [VM_SLOTS-1:0] len_valid;
  logic [7:0]       line_mem [DEPTH];
  logic [SW-1:0]    len_idx;
  logic [AW-1:0]    line_addr;
  logic [POS_W-1:0] len_q;
  logic [7:0]       line_q;

  assign len_idx   = req.len_slot[SW-1:0];
  assign line_addr = AW'(int'(req.line_slot) * LINE_SIZE + int'(req.line_pos));

  // Mark a length entry written; an unwritten entry reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      len_valid <= '0;
    end else if (req.len_we) begin
      len_valid[len_idx] <= 1'b1;
    end
  end

  // Line length memory, one entry per slot
  always_ff @(posedge clk) begin
    if (req.len_we) begin
      len_mem[len_idx] <= req.len_wdata;
    end
    if (req.len_rd) begin
      len_q <= len_valid[len_idx] ? len_mem[len_idx] : '0;
    end
  end

  // Line store, one row of LINE_SIZE bytes per slot
  always_ff @(posedge clk) begin
    if (req.line_we) begin
      line_mem[line_addr] <= req.line_wdata;
    end
    if (req.line_rd) begin
      line_q <= line_mem[line_addr];
    end
  end

  assign rsp.len_q  = len_q;
  assign rsp.line_q = line_q;

endmodule

>>> rtl/scvm_seq.sv
module scvm_seq #(
  parameter int VM_SLOTS  = 16,
  parameter int LINE_SIZE = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  scvm_item_if.sink                     item,
  input  logic [scvm_pkg::MASK_W-1:0]   mask,
  input  logic                          emit_ok,
  output logic                          emit_valid,
  output scvm_pkg::result_t             emit,
  output scvm_pkg::store_req_t          req,
  input  scvm_pkg::store_rsp_t          rsp
);
  import scvm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WLEN,
    S_ESC,
    S_ONE,
    S_ROT,
    S_K2,
    S_REP
  } state_t;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(VM_SLOTS - 1);
  localparam logic [POS_W-1:0]  LAST_POS  = POS_W'(LINE_SIZE - 1);

  state_t            state;
  logic [7:0]        prev_char;
  logic [SLOT_W-1:0] focus;
  logic              verbose;
  logic [SLOT_W-1:0] vm_q;
  logic [7:0]        c_q;
  event_kind_t       one_kind;
  logic [7:0]        one_byte;
  logic [SLOT_W-1:0] rot_f;
  logic [SLOT_W-1:0] rot_cnt;
  logic [POS_W-1:0]  rep_len;
  logic [POS_W-1:0]  rep_idx;

  logic              accept;
  logic              prev_esc;
  logic              slot_ok;
  logic [SLOT_W-1:0] rot_next;
  logic              rot_done;
  logic              rep_last;
  logic [POS_W-1:0]  len_next;

  assign item.ready = (state == S_IDLE);
  assign accept     = item.valid && item.ready;
  assign prev_esc   = (prev_char == ESC_CODE);
  assign slot_ok    = int'(item.source_vm) < VM_SLOTS;
  assign rot_next   = (rot_f == LAST_SLOT) ? '0 : rot_f + SLOT_W'(1);
  assign rot_done   = mask[rot_next] || (rot_cnt == LAST_SLOT);
  assign rep_last   = (rep_idx + POS_W'(1)) == rep_len;

  // End of line restarts the length, otherwise advance and wrap
  always_comb begin
    if (c_q == CHAR_LF || c_q == CHAR_CR) begin
      len_next = '0;
    end else if (rsp.len_q == LAST_POS) begin
      len_next = '0;
    end else begin
      len_next = rsp.len_q + POS_W'(1);
    end
  end

  // Drive the result beat for the current state
  always_comb begin
    emit_valid   = 1'b0;
    emit.kind    = one_kind;
    emit.data    = one_byte;
    emit.focus   = focus;
    emit.verbose = verbose;
    emit.last    = 1'b1;
    case (state)
      S_ESC: begin
        emit_valid = 1'b1;
        emit.kind  = EV_CHAR_VM;
        emit.data  = ESC_CODE;
        emit.last  = 1'b0;
      end
      S_ONE: begin
        emit_valid = 1'b1;
      end
      S_K2: begin
        emit_valid = 1'b1;
        emit.kind  = EV_FOCUS;
        emit.data  = '0;
        emit.last  = (rsp.len_q == '0);
      end
      S_REP: begin
        emit_valid = 1'b1;
        emit.kind  = EV_CHAR_OUT;
        emit.data  = (rsp.line_q == '0) ? CHAR_SPACE : rsp.line_q;
        emit.last  = rep_last;
      end
      default: begin
        emit_valid = 1'b0;
      end
    endcase
  end

  // Issue store reads and writes
  always_comb begin
    req = '0;
    case (state)
      S_IDLE: begin
        req.len_rd   = accept && !item.command && slot_ok;
        req.len_slot = item.source_vm;
      end
      S_WLEN: begin
        req.line_we    = 1'b1;
        req.line_slot  = vm_q;
        req.line_pos   = rsp.len_q;
        req.line_wdata = c_q;
        req.len_we     = 1'b1;
        req.len_slot   = vm_q;
        req.len_wdata  = len_next;
      end
      S_ROT: begin
        req.len_rd   = rot_done;
        req.len_slot = rot_next;
      end
      S_K2: begin
        req.line_rd   = emit_ok && (rsp.len_q != '0);
        req.line_slot = focus;
        req.line_pos  = '0;
      end
      S_REP: begin
        req.line_rd   = emit_ok && !rep_last;
        req.line_slot = focus;
        req.line_pos  = rep_idx + POS_W'(1);
      end
      default: begin
        req = '0;
      end
    endcase
  end

  // Sequence decode, rotation and replay
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      prev_char <= '0;
      focus     <= SLOT_W'(1);
      verbose   <= 1'b1;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            c_q  <= item.data_byte;
            vm_q <= item.source_vm;
            if (!item.command) begin
              one_kind <= EV_CHAR_OUT;
              one_byte <= (item.data_byte == '0) ? CHAR_SPACE : item.data_byte;
              state    <= slot_ok ? S_WLEN : S_ONE;
            end else if (item.data_byte == ESC_CODE) begin
              if (prev_esc) begin
                prev_char <= '0;
                one_kind  <= EV_BREAK;
                one_byte  <= '0;
                state     <= S_ONE;
              end else begin
                prev_char <= ESC_CODE;
              end
            end else if (item.data_byte == CHAR_N && prev_esc) begin
              prev_char <= '0;
              rot_f     <= focus;
              rot_cnt   <= '0;
              state     <= S_ROT;
            end else if (item.data_byte == CHAR_S && prev_esc) begin
              prev_char <= '0;
              verbose   <= ~verbose;
              one_kind  <= EV_VERBOSE;
              one_byte  <= '0;
              state     <= S_ONE;
            end else begin
              prev_char <= item.data_byte;
              one_kind  <= EV_CHAR_VM;
              one_byte  <= item.data_byte;
              if (mask[focus]) begin
                state <= prev_esc ? S_ESC : S_ONE;
              end
            end
          end
        end
        S_WLEN: begin
          state <= S_ONE;
        end
        S_ESC: begin
          if (emit_ok) begin
            state <= S_ONE;
          end
        end
        S_ONE: begin
          if (emit_ok) begin
            state <= S_IDLE;
          end
        end
        S_ROT: begin
          rot_f   <= rot_next;
          rot_cnt <= rot_cnt + SLOT_W'(1);
          if (rot_done) begin
            focus <= rot_next;
            state <= S_K2;
          end
        end
        S_K2: begin
          if (emit_ok) begin
            rep_len <= rsp.len_q;
            rep_idx <= '0;
            state   <= (rsp.len_q == '0) ? S_IDLE : S_REP;
          end
        end
        S_REP: begin
          if (emit_ok) begin
            if (rep_last) begin
              state <= S_IDLE;
            end else begin
              rep_idx <= rep_idx + POS_W'(1);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/serial_console_vm_mux_core.sv
// Channel  | Dir | Beat
// item     | in  | command, source_vm, data_byte
// result   | out | event_kind, out_byte, focus_slot, verbose_on, last_of_run
// cfg      | in  | cfg_we, cfg_wdata (active_vm_mask)
//
// One item is in flight at a time. A VM byte is written to its line, then
// echoed (only echoed for a slot at or above VM_SLOTS). ESC n walks the slot
// mask one slot a cycle, then, while the result register accepts, gives one
// result per cycle for the focus beat and each replayed byte.
// Reset is synchronous; line lengths clear at once, no clearing pass.
// A stalled result holds the sequencer; the next item waits for the result
// register to accept the last beat of the current one.
module serial_console_vm_mux_core #(
  parameter int VM_SLOTS  = 16,
  parameter int LINE_SIZE = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  scvm_item_if.sink                    item,
  scvm_result_if.source                result,
  input  logic                         cfg_we,
  input  logic [scvm_pkg::MASK_W-1:0]  cfg_wdata
);
  import scvm_pkg::*;

  logic [MASK_W-1:0] active_mask;
  logic              out_valid;
  result_t           out_q;
  logic              emit_ok;
  logic              emit_valid;
  result_t           emit;
  store_req_t        req;
  store_rsp_t        rsp;

  // Hold the active slot mask
  always_ff @(posedge clk) begin
    if (rst) begin
      active_mask <= '0;
    end else if (cfg_we) begin
      active_mask <= cfg_wdata;
    end
  end

  scvm_seq #(
    .VM_SLOTS  (VM_SLOTS),
    .LINE_SIZE (LINE_SIZE)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .mask       (active_mask),
    .emit_ok    (emit_ok),
    .emit_valid (emit_valid),
    .emit       (emit),
    .req        (req),
    .rsp        (rsp)
  );

  scvm_store #(
    .VM_SLOTS  (VM_SLOTS),
    .LINE_SIZE (LINE_SIZE)
  ) u_store (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // Result register: load a new beat when empty or being drained
  assign emit_ok = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_valid && emit_ok) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_valid && emit_ok) begin
      out_q <= emit;
    end
  end

  assign result.valid       = out_valid;
  assign result.event_kind  = out_q.kind;
  assign result.out_byte    = out_q.data;
  assign result.focus_slot  = out_q.focus;
  assign result.verbose_on  = out_q.verbose;
  assign result.last_of_run = out_q.last;

endmodule

>>> rtl/scvm_checker.sv
module scvm_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] event_kind,
  input logic [7:0] out_byte,
  input logic [3:0] focus_slot,
  input logic       verbose_on,
  input logic       last_of_run
);
  import scvm_pkg::*;

  // Result channel is empty right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // A stalled beat stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat withdrawn while stalled");

  // A stalled beat keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable({event_kind, out_byte, focus_slot, verbose_on,
                                         last_of_run}))
    else $error("result payload changed while stalled");

  // Control events carry no character
  a_ctrl_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_kind == EV_FOCUS || event_kind == EV_VERBOSE ||
                  event_kind == EV_BREAK) |-> out_byte == '0)
    else $error("control event with nonzero byte");

  // Console echo shows zero as a space
  a_echo_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind == EV_CHAR_OUT |-> out_byte != '0)
    else $error("console char out carries zero");

endmodule

bind serial_console_vm_mux_core scvm_checker u_scvm_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .event_kind  (result.event_kind),
  .out_byte    (result.out_byte),
  .focus_slot  (result.focus_slot),
  .verbose_on  (result.verbose_on),
  .last_of_run (result.last_of_run)
);

>>> tb/tb.sv
module tb;
  import scvm_pkg::*;

  localparam bit CMD_VM_WRITE  = 1'b0;
  localparam bit CMD_SERIAL_RX = 1'b1;
  localparam int SETTLE_CYCLES = 40;
  localparam int LIMIT_CYCLES  = 300000;
  localparam int HALF_ITEMS    = 7;

  // Track console state and hold the result beats still owed by the block
  class console_tracker;
    bit [15:0] active_mask;
    bit [7:0]  prev_char;
    bit [3:0]  focus;
    bit        verbose;
    bit [7:0]  line_text [0:511];
    bit [4:0]  line_len [0:15];
    result_t   pending [$];
    result_t   batch [$];
    int        errors;
    int        beats_checked;
    int        focus_moves;
    int        breaks;

    function new();
      focus   = 4'd1;
      verbose = 1'b1;
    endfunction

    function void add_event(event_kind_t kind, bit [7:0] data);
      result_t e;
      e      = '0;
      e.kind = kind;
      e.data = data;
      batch.push_back(e);
    endfunction

    // Predict the beats caused by one accepted item and queue them
    function void take_item(bit cmd, bit [3:0] vm, bit [7:0] b);
      bit [3:0] f;
      bit [4:0] len;
      bit       found;
      batch.delete();
      if (cmd == CMD_VM_WRITE) begin
        add_event(EV_CHAR_OUT, (b == 8'h00) ? CHAR_SPACE : b);
        len = line_len[vm];
        line_text[{vm, len}] = b;
        if (b == CHAR_LF || b == CHAR_CR) line_len[vm] = '0;
        else line_len[vm] = len + 5'd1;
      end else if (b == ESC_CODE) begin
        if (prev_char == ESC_CODE) begin
          prev_char = '0;
          breaks++;
          add_event(EV_BREAK, 8'h00);
        end else begin
          prev_char = b;
        end
      end else if (b == CHAR_N && prev_char == ESC_CODE) begin
        // Step forward to the next active slot; with none, land where we began
        f     = focus;
        found = 1'b0;
        for (int i = 0; i < 16; i++) begin
          if (!found) begin
            f = f + 4'd1;
            found = active_mask[f];
          end
        end
        focus = f;
        focus_moves++;
        add_event(EV_FOCUS, 8'h00);
        for (int i = 0; i < line_len[f]; i++) begin
          add_event(EV_CHAR_OUT, (line_text[{f, 5'(i)}] == 8'h00) ? CHAR_SPACE
                                                                   : line_text[{f, 5'(i)}]);
        end
        prev_char = '0;
      end else if (b == CHAR_S && prev_char == ESC_CODE) begin
        verbose   = ~verbose;
        prev_char = '0;
        add_event(EV_VERBOSE, 8'h00);
      end else begin
        if (active_mask[focus]) begin
          if (prev_char == ESC_CODE) add_event(EV_CHAR_VM, ESC_CODE);
          add_event(EV_CHAR_VM, b);
        end
        prev_char = b;
      end
      foreach (batch[k]) begin
        batch[k].focus   = focus;
        batch[k].verbose = verbose;
        batch[k].last    = (k == batch.size() - 1);
        pending.push_back(batch[k]);
      end
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    // Compare one accepted beat with the oldest expected beat
    task check_beat(logic [2:0] kind, logic [7:0] data, logic [3:0] slot,
                    logic verbose_on, logic last);
      result_t e;
      if (pending.size() == 0) begin
        report($sformatf("beat kind %0d byte %02h with nothing expected", kind, data));
        return;
      end
      e = pending.pop_front();
      beats_checked++;
      if (kind !== e.kind)
        report($sformatf("event_kind %0d, expected %0d", kind, e.kind));
      if (data !== e.data)
        report($sformatf("out_byte %02h, expected %02h", data, e.data));
      if (slot !== e.focus)
        report($sformatf("focus_slot %0d, expected %0d", slot, e.focus));
      if (verbose_on !== e.verbose)
        report($sformatf("verbose_on %0b, expected %0b", verbose_on, e.verbose));
      if (last !== e.last)
        report($sformatf("last_of_run %0b, expected %0b", last, e.last));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  scvm_item_if   item_ch();
  scvm_result_if result_ch();

  console_tracker tracker = new();

  int tx_idle_pct;
  int rx_idle_pct;
  int cycles;
  int items_sent;
  int mask_writes;

  serial_console_vm_mux_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .item     (item_ch),
    .result   (result_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bound the run
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("run stopped after %0d cycles without finishing", cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Check accepted beats and stall the result channel at random
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready)
      tracker.check_beat(result_ch.event_kind, result_ch.out_byte, result_ch.focus_slot,
                         result_ch.verbose_on, result_ch.last_of_run);
    result_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Offer one item, idling first at random, and hold it until accepted
  task automatic send_byte(input bit cmd, input bit [3:0] vm, input bit [7:0] b);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid     <= 1'b1;
    item_ch.command   <= cmd;
    item_ch.source_vm <= vm;
    item_ch.data_byte <= b;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    tracker.take_item(cmd, vm, b);
    items_sent++;
  endtask

  task automatic send_escape(input bit [7:0] b);
    send_byte(CMD_SERIAL_RX, 4'd0, ESC_CODE);
    send_byte(CMD_SERIAL_RX, 4'd0, b);
  endtask

  // Drop valid, drain every owed beat, then let the block go quiet
  task automatic settle();
    item_ch.valid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mask(input bit [15:0] m);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.active_mask = m;
    mask_writes++;
  endtask

  task automatic long_line(input bit [3:0] vm, input int n);
    repeat (n) send_byte(CMD_VM_WRITE, vm, 8'($urandom_range(32, 126)));
  endtask

  // One random sequence: mostly well-formed escapes and VM writes, some noise
  task automatic random_sequence();
    int       pick;
    bit [3:0] vm;
    bit [7:0] b;
    pick = $urandom_range(0, 99);
    vm   = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
    case ($urandom_range(0, 19))
      0: b = CHAR_CR;
      1: b = CHAR_LF;
      2: b = 8'h00;
      default: b = 8'($urandom_range(0, 255));
    endcase
    if (pick < 40) send_byte(CMD_VM_WRITE, vm, b);
    else if (pick < 44) long_line(vm, $urandom_range(2, 8));
    else if (pick < 60) send_escape(CHAR_N);
    else if (pick < 68) send_escape(CHAR_S);
    else if (pick < 75) send_escape(ESC_CODE);
    else if (pick < 85) send_escape(8'($urandom_range(0, 255)));
    else if (pick < 90) send_byte(CMD_SERIAL_RX, vm, ESC_CODE);
    else send_byte(CMD_SERIAL_RX, vm, b);
  endtask

  initial begin
    int start_count;
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    item_ch.valid     = 1'b0;
    item_ch.command   = CMD_VM_WRITE;
    item_ch.source_vm = '0;
    item_ch.data_byte = '0;
    result_ch.ready   = 1'b0;
    tx_idle_pct       = 12;
    rx_idle_pct       = 48;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // No active VM: serial input is dropped and rotation returns to the same slot
    write_mask(16'h0000);
    send_byte(CMD_VM_WRITE, 4'd1, 8'h41);
    send_byte(CMD_VM_WRITE, 4'd1, 8'h00);
    send_byte(CMD_SERIAL_RX, 4'd0, 8'h78);
    send_escape(CHAR_N);
    settle();

    // All VMs active: extremes, line resets and every escape
    write_mask(16'hffff);
    send_byte(CMD_VM_WRITE, 4'd0, 8'hff);
    send_byte(CMD_VM_WRITE, 4'd15, 8'h7f);
    send_byte(CMD_VM_WRITE, 4'd2, 8'h62);
    send_byte(CMD_VM_WRITE, 4'd1, CHAR_CR);
    send_byte(CMD_VM_WRITE, 4'd3, CHAR_LF);
    send_byte(CMD_SERIAL_RX, 4'd0, 8'h71);
    send_escape(ESC_CODE);
    send_escape(CHAR_S);
    send_escape(8'h71);
    send_escape(CHAR_N);
    send_byte(CMD_SERIAL_RX, 4'd15, 8'h00);
    send_byte(CMD_SERIAL_RX, 4'd0, 8'hff);
    send_escape(CHAR_N);

    // Random part in three idling phases, two mask settings each
    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 12 : (phase == 1) ? 48 : 0;
      rx_idle_pct = (phase == 0) ? 48 : (phase == 1) ? 12 : 0;
      for (int half = 0; half < 2; half++) begin
        settle();
        case (phase * 2 + half)
          0: write_mask(16'h0001);
          1: write_mask(16'h8000);
          2: write_mask(16'($urandom));
          3: write_mask(16'($urandom & $urandom));
          4: write_mask(16'hffff);
          default: write_mask(16'($urandom));
        endcase
        // Wrap one line past its end once
        if (phase == 0 && half == 0) long_line(4'd5, 33);
        start_count = items_sent;
        while (items_sent - start_count < HALF_ITEMS) random_sequence();
      end
    end

    settle();
    $display("Sent %0d items under %0d mask settings, %0d result beats checked.",
             items_sent, mask_writes, tracker.beats_checked);
    $display("Focus moved %0d times, %0d debugger breaks raised.",
             tracker.focus_moves, tracker.breaks);
    if (tracker.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", tracker.errors);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
